FILE: src/hbml_pkg.sv
package hbml_pkg;

    localparam int DEF_MAX_BUCKETS = 256;
    localparam int DEF_MAX_MEMBERS = 1024;
    localparam int DEF_MAX_RUN     = 64;

    localparam int          HASH_SHIFT     = 5;
    localparam logic [10:0] TABLE_WORD_MAX = 11'h7FF;

    // request types
    localparam logic [1:0] REQ_LOAD_TABLE  = 2'd0;
    localparam logic [1:0] REQ_LOAD_MEMBER = 2'd1;
    localparam logic [1:0] REQ_NAME_BYTE   = 2'd2;
    localparam logic [1:0] REQ_END_NAME    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_MEMBER    = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_BAD_ORDER = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    // configuration register indexes
    localparam logic CFG_BUCKET_COUNT = 1'b0;
    localparam logic CFG_MEMBER_COUNT = 1'b1;

    typedef struct packed {
        logic       accept;      // input transfer this cycle
        logic       div_start;
        logic       tbl_rd_lo;   // read table[idx]
        logic       tbl_rd_hi;   // read table[idx+1], latch start
        logic       run_init;
        logic       mem_rd;
        logic       out_member;
        logic       out_flag;
        logic       flag_set;
        logic [1:0] flag_code;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic nm_zero;
        logic bad;
        logic empty;
        logic run_none;   // nothing to emit before the truncation flag
        logic run_last;
        logic run_trunc;
        logic out_free;
    } sts_t;

endpackage

FILE: src/hbml_ctrl.sv
module hbml_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic [1:0]    s_req_type,
    output logic          s_ready,
    input  hbml_pkg::sts_t sts,
    output hbml_pkg::cmd_t cmd
);
    import hbml_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_TA   = 3'd2;
    localparam logic [2:0] S_TB   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_MRD  = 3'd5;
    localparam logic [2:0] S_MWR  = 3'd6;
    localparam logic [2:0] S_FLAG = 3'd7;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = s_valid && s_ready;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && s_req_type == REQ_END_NAME) begin
                    if (sts.nm_zero) begin
                        cmd.flag_set  = 1'b1;
                        cmd.flag_code = ST_NONE;
                        state_next    = S_FLAG;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_TA;
                end
            end
            S_TA: begin
                cmd.tbl_rd_lo = 1'b1;
                state_next    = S_TB;
            end
            S_TB: begin
                cmd.tbl_rd_hi = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK: begin
                if (sts.bad) begin
                    cmd.flag_set  = 1'b1;
                    cmd.flag_code = ST_BAD_ORDER;
                    state_next    = S_FLAG;
                end else if (sts.empty) begin
                    cmd.flag_set  = 1'b1;
                    cmd.flag_code = ST_NONE;
                    state_next    = S_FLAG;
                end else if (sts.run_none) begin
                    cmd.flag_set  = 1'b1;
                    cmd.flag_code = ST_TRUNC;
                    state_next    = S_FLAG;
                end else begin
                    cmd.run_init = 1'b1;
                    state_next   = S_MRD;
                end
            end
            S_MRD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MWR;
            end
            S_MWR: begin
                if (sts.out_free) begin
                    cmd.out_member = 1'b1;
                    if (!sts.run_last) begin
                        state_next = S_MRD;
                    end else if (sts.run_trunc) begin
                        cmd.flag_set  = 1'b1;
                        cmd.flag_code = ST_TRUNC;
                        state_next    = S_FLAG;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLAG: begin
                if (sts.out_free) begin
                    cmd.out_flag = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/hbml_dpath.sv
module hbml_dpath #(
    parameter int MAX_BUCKETS = hbml_pkg::DEF_MAX_BUCKETS,
    parameter int MAX_MEMBERS = hbml_pkg::DEF_MAX_MEMBERS,
    parameter int MAX_RUN     = hbml_pkg::DEF_MAX_RUN
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [10:0]    cfg_wdata,
    input  logic [1:0]     s_req_type,
    input  logic [10:0]    s_load_index,
    input  logic [31:0]    s_load_word,
    input  logic [7:0]     s_name_byte,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_member_word,
    output logic [1:0]     m_status,
    output logic           m_last,
    input  hbml_pkg::cmd_t cmd,
    output hbml_pkg::sts_t sts
);
    import hbml_pkg::*;

    localparam int TAW = $clog2(MAX_BUCKETS + 1);
    localparam int MAW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

    // configuration
    logic [8:0]  bc_reg;
    logic [10:0] mc_reg;
    logic [8:0]  nb;
    logic [10:0] nm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg <= 9'd1;
            mc_reg <= 11'd0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_BUCKET_COUNT) begin
                bc_reg <= cfg_wdata[8:0];
            end
            if (cfg_index == CFG_MEMBER_COUNT) begin
                mc_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        if (bc_reg == 9'd0) begin
            nb = 9'd1;
        end else if ({23'd0, bc_reg} > 32'(MAX_BUCKETS)) begin
            nb = 9'(MAX_BUCKETS);
        end else begin
            nb = bc_reg;
        end
        if ({21'd0, mc_reg} > 32'(MAX_MEMBERS)) begin
            nm = 11'(MAX_MEMBERS);
        end else begin
            nm = mc_reg;
        end
    end

    // running hash: hash*31 + byte
    logic [31:0] hash_reg, hash_next;

    always_comb begin
        hash_next = hash_reg;
        if (cmd.accept && s_req_type == REQ_NAME_BYTE) begin
            hash_next = (hash_reg << HASH_SHIFT) - hash_reg + {24'd0, s_name_byte};
        end else if (cmd.accept && s_req_type == REQ_END_NAME) begin
            hash_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= 32'd0;
        end else begin
            hash_reg <= hash_next;
        end
    end

    // bit-serial restoring modulo, one dividend bit per cycle
    logic [31:0] dvd_reg;
    logic [8:0]  rem_reg;
    logic [5:0]  cnt_reg;
    logic [9:0]  trial;
    logic        trial_ge;

    assign trial    = {rem_reg, dvd_reg[31]};
    assign trial_ge = trial >= {1'b0, nb};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (cmd.div_start) begin
            cnt_reg <= 6'd32;
        end else if (cnt_reg != 6'd0) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg <= hash_reg;
            rem_reg <= 9'd0;
        end else if (cnt_reg != 6'd0) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= trial_ge ? 9'(trial - {1'b0, nb}) : trial[8:0];
        end
    end

    // bucket start table
    logic [10:0]    table_mem [MAX_BUCKETS + 1];
    logic [10:0]    tbl_q;
    logic [TAW-1:0] tbl_addr;
    logic [10:0]    tbl_wdata;
    logic           tbl_we;

    assign tbl_we    = cmd.accept && s_req_type == REQ_LOAD_TABLE &&
                       ({21'd0, s_load_index} <= 32'(MAX_BUCKETS));
    assign tbl_wdata = (s_load_word > {21'd0, TABLE_WORD_MAX}) ? TABLE_WORD_MAX
                                                                : s_load_word[10:0];
    assign tbl_addr  = cmd.tbl_rd_hi ? TAW'({1'b0, rem_reg} + 10'd1) : TAW'(rem_reg);

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            table_mem[TAW'(s_load_index)] <= tbl_wdata;
        end
        if (cmd.tbl_rd_lo || cmd.tbl_rd_hi) begin
            tbl_q <= table_mem[tbl_addr];
        end
    end

    // member store
    logic [31:0] member_mem [MAX_MEMBERS];
    logic [31:0] mem_q;
    logic [10:0] cursor_reg;
    logic        mem_we;

    assign mem_we = cmd.accept && s_req_type == REQ_LOAD_MEMBER &&
                    ({21'd0, s_load_index} < 32'(MAX_MEMBERS));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            member_mem[MAW'(s_load_index)] <= s_load_word;
        end
        if (cmd.mem_rd) begin
            mem_q <= member_mem[MAW'(cursor_reg)];
        end
    end

    // bucket bounds check; tbl_q holds the end word during the check
    logic [10:0] start_reg;
    logic [10:0] run_len;
    logic        len_trunc;
    logic [6:0]  n_emit;
    logic [6:0]  left_reg;
    logic        trunc_reg;
    logic [1:0]  flag_reg;

    assign run_len   = tbl_q - start_reg;
    assign len_trunc = {21'd0, run_len} > 32'(MAX_RUN);
    assign n_emit    = len_trunc ? 7'(MAX_RUN - 1) : run_len[6:0];

    always_ff @(posedge aclk) begin
        if (cmd.tbl_rd_hi) begin
            start_reg <= tbl_q;
        end
        if (cmd.run_init) begin
            cursor_reg <= start_reg;
            left_reg   <= n_emit;
            trunc_reg  <= len_trunc;
        end else if (cmd.out_member) begin
            cursor_reg <= cursor_reg + 11'd1;
            left_reg   <= left_reg - 7'd1;
        end
        if (cmd.flag_set) begin
            flag_reg <= cmd.flag_code;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_member || cmd.out_flag) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_member) begin
            out_word_reg   <= mem_q;
            out_status_reg <= ST_MEMBER;
            out_last_reg   <= (left_reg == 7'd1) && !trunc_reg;
        end else if (cmd.out_flag) begin
            out_word_reg   <= 32'd0;
            out_status_reg <= flag_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_member_word = out_word_reg;
    assign m_status      = out_status_reg;
    assign m_last        = out_last_reg;

    assign sts.div_busy  = cnt_reg != 6'd0;
    assign sts.nm_zero   = nm == 11'd0;
    assign sts.bad       = (start_reg > tbl_q) || (tbl_q > nm);
    assign sts.empty     = start_reg == tbl_q;
    assign sts.run_none  = n_emit == 7'd0;
    assign sts.run_last  = left_reg == 7'd1;
    assign sts.run_trunc = trunc_reg;
    assign sts.out_free  = !out_valid_reg || m_ready;

endmodule

FILE: src/hash_bucket_member_lookup.sv
// Bucketed hash lookup. Load the bucket start table (MAX_BUCKETS+1 words, the
// last one marking the end of the final bucket) and the member store through
// the input channel, then send the name a byte at a time and close it with an
// end-of-name item. Loads and name bytes are taken whenever the block is idle.
// A lookup reduces the hash with a bit-serial modulo unit, reads the two table
// words and then streams the bucket's members, each read through the single
// read port of the member store before it goes to the output register. No
// input is taken until the last result is in the output register. The stores
// have no reset: entries must be loaded before use.
module hash_bucket_member_lookup #(
    parameter int MAX_BUCKETS = hbml_pkg::DEF_MAX_BUCKETS,
    parameter int MAX_MEMBERS = hbml_pkg::DEF_MAX_MEMBERS,
    parameter int MAX_RUN     = hbml_pkg::DEF_MAX_RUN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [10:0] s_load_index,
    input  logic [31:0] s_load_word,
    input  logic [7:0]  s_name_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_member_word,
    output logic [1:0]  m_status,
    output logic        m_last
);
    import hbml_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hbml_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    hbml_dpath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_MEMBERS (MAX_MEMBERS),
        .MAX_RUN     (MAX_RUN)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_req_type    (s_req_type),
        .s_load_index  (s_load_index),
        .s_load_word   (s_load_word),
        .s_name_byte   (s_name_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_member_word (m_member_word),
        .m_status      (m_status),
        .m_last        (m_last),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
